>>> rtl/blc_pkg.sv
// Package for the byte capacity LRU cache unit: status codes, config indexes,
// controller-to-datapath command struct. No dependencies.
package blc_pkg;

  localparam logic [2:0] StGetMiss  = 3'd0;
  localparam logic [2:0] StGetHit   = 3'd1;
  localparam logic [2:0] StAdded    = 3'd2;
  localparam logic [2:0] StUpdated  = 3'd3;
  localparam logic [2:0] StRejected = 3'd4;

  localparam logic CfgCapacity = 1'b0;
  localparam logic CfgMaxElem  = 1'b1;

  localparam logic [31:0] CapReset   = 32'd209715200;
  localparam logic [31:0] MaxElReset = 32'd10485760;

  typedef struct packed {
    logic capture;   // latch request, clear evict count
    logic lookup;    // register key match result
    logic evict;     // evict oldest valid slot
    logic promote;   // promote hit slot
    logic update;    // rewrite hit slot size and handle, and promote it
    logic insert;    // insert into free slot
  } cmd_t;

  typedef struct packed {
    logic op;
    logic hit;
    logic too_big;
    logic need_evict;
  } sts_t;

endpackage

>>> rtl/blc_datapath.sv
// Datapath of the byte capacity LRU cache unit: slot table, ranks, totals.
// Depends on blc_pkg.
module blc_datapath #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  blc_pkg::cmd_t       cmd_i,
  output blc_pkg::sts_t       sts_o,
  input  logic                op_i,
  input  logic [63:0]         key_i,
  input  logic [31:0]         data_handle_i,
  input  logic [31:0]         element_size_i,
  input  logic [31:0]         cap_i,
  input  logic [31:0]         max_el_i,
  output logic [31:0]         hit_handle_o,
  output logic [4:0]          evicted_count_o,
  output logic [4:0]          entry_count_o,
  output logic [39:0]         used_bytes_o
);
  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  logic [KEY_BITS-1:0] key_q;
  logic [31:0]         handle_q, size_q;
  logic                op_q;
  logic [KEY_BITS-1:0] slot_key_q    [ENTRIES];
  logic [31:0]         slot_handle_q [ENTRIES];
  logic [31:0]         slot_size_q   [ENTRIES];
  logic [IW-1:0]       slot_rank_q   [ENTRIES];
  logic [ENTRIES-1:0]  slot_valid_q;
  logic [CW-1:0]       count_q;
  logic [39:0]         total_q;
  logic [CW-1:0]       evicted_q;
  logic                hit_q;
  logic [IW-1:0]       hit_idx_q;

  logic [ENTRIES-1:0]  match;
  logic                match_any, free_any;
  logic [IW-1:0]       match_idx, free_idx, old_idx;
  logic [IW-1:0]       promo_rank;

  always_comb begin
    match_any = 1'b0; match_idx = '0;
    free_any = 1'b0;  free_idx = '0;
    old_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = slot_valid_q[i] && (slot_key_q[i] == key_q);
      if (match[i] && !match_any) begin
        match_any = 1'b1; match_idx = IW'(i);
      end
      if (!slot_valid_q[i] && !free_any) begin
        free_any = 1'b1; free_idx = IW'(i);
      end
      // oldest valid slot has rank count-1
      if (slot_valid_q[i] && ({1'b0, slot_rank_q[i]} == (IW+1)'(count_q - CW'(1))))
        old_idx = IW'(i);
    end
  end

  assign promo_rank = slot_rank_q[hit_idx_q];
  assign sts_o.op = op_q;
  assign sts_o.hit = hit_q;
  assign sts_o.too_big = size_q > max_el_i;
  assign sts_o.need_evict = (count_q != '0) &&
      ((total_q + 40'(size_q) > 40'(cap_i)) || (count_q >= CW'(ENTRIES)));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= op_i; key_q <= key_i[KEY_BITS-1:0];
      handle_q <= data_handle_i; size_q <= element_size_i;
    end
    if (cmd_i.lookup) hit_idx_q <= match_idx;
    if (cmd_i.update) begin
      slot_size_q[hit_idx_q] <= size_q;
      slot_handle_q[hit_idx_q] <= handle_q;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (cmd_i.promote || cmd_i.update) begin
        if (IW'(i) == hit_idx_q) slot_rank_q[i] <= '0;
        else if (slot_valid_q[i] && slot_rank_q[i] < promo_rank)
          slot_rank_q[i] <= slot_rank_q[i] + IW'(1);
      end
      if (cmd_i.insert) begin
        if (IW'(i) == free_idx) begin
          slot_rank_q[i] <= '0; slot_key_q[i] <= key_q;
          slot_handle_q[i] <= handle_q; slot_size_q[i] <= size_q;
        end else if (slot_valid_q[i]) slot_rank_q[i] <= slot_rank_q[i] + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0; count_q <= '0; total_q <= '0;
      evicted_q <= '0; hit_q <= 1'b0;
    end else begin
      if (cmd_i.capture) evicted_q <= '0;
      if (cmd_i.lookup) hit_q <= match_any;
      if (cmd_i.update)
        total_q <= total_q - 40'(slot_size_q[hit_idx_q]) + 40'(size_q);
      if (cmd_i.evict) begin
        slot_valid_q[old_idx] <= 1'b0;
        total_q <= total_q - 40'(slot_size_q[old_idx]);
        count_q <= count_q - CW'(1);
        evicted_q <= evicted_q + CW'(1);
      end
      if (cmd_i.insert && free_any) begin
        slot_valid_q[free_idx] <= 1'b1;
        count_q <= count_q + CW'(1);
        total_q <= total_q + 40'(size_q);
      end
    end
  end

  assign hit_handle_o = slot_handle_q[hit_idx_q];
  assign evicted_count_o = 5'(evicted_q);
  assign entry_count_o = 5'(count_q);
  assign used_bytes_o = total_q;
endmodule

>>> rtl/blc_ctrl.sv
// Controller of the byte capacity LRU cache unit: sequences lookup, evict,
// insert and result hold. Depends on blc_pkg.
module blc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  blc_pkg::sts_t sts_i,
  output blc_pkg::cmd_t cmd_o,
  output logic [2:0]    status_o,
  output logic          show_hit_o
);
  typedef enum logic [2:0] {Idle, Lookup, Decide, Evict, Done} state_e;
  state_e state_q;
  logic [2:0] status_q;
  logic show_q;

  assign in_ready_o = (state_q == Idle);
  assign out_valid_o = (state_q == Done);
  assign status_o = status_q;
  assign show_hit_o = show_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.capture = (state_q == Idle) && in_valid_i;
    cmd_o.lookup = (state_q == Lookup);
    if (state_q == Decide) begin
      if (!sts_i.op) cmd_o.promote = sts_i.hit;
      else if (!sts_i.too_big && sts_i.hit) cmd_o.update = 1'b1;
    end
    if (state_q == Evict) begin
      cmd_o.evict = sts_i.need_evict;
      cmd_o.insert = !sts_i.need_evict;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle; status_q <= blc_pkg::StGetMiss; show_q <= 1'b0;
    end else begin
      case (state_q)
        Idle:   if (in_valid_i) state_q <= Lookup;
        Lookup: state_q <= Decide;
        Decide: begin
          show_q <= 1'b0;
          state_q <= Done;
          if (!sts_i.op) begin
            status_q <= sts_i.hit ? blc_pkg::StGetHit : blc_pkg::StGetMiss;
            show_q <= sts_i.hit;
          end else if (sts_i.too_big) status_q <= blc_pkg::StRejected;
          else if (sts_i.hit) status_q <= blc_pkg::StUpdated;
          else begin
            status_q <= blc_pkg::StAdded;
            state_q <= Evict;
          end
        end
        Evict:  if (!sts_i.need_evict) state_q <= Done;
        Done:   if (out_ready_i) state_q <= Idle;
        default: state_q <= Idle;
      endcase
    end
  end
endmodule

>>> rtl/byte_capacity_lru_cache_unit.sv
// Top level of the byte capacity LRU cache unit: config registers plus
// controller and datapath. Depends on blc_pkg, blc_ctrl, blc_datapath.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  request  | in_valid_i / in_ready_o | op_i key_i data_handle_i element_size_i
//  result   | out_valid_o/out_ready_i | status_o hit_handle_o evicted_count_o
//           |                         | entry_count_o used_bytes_o
//  config   | cfg_valid_i/cfg_ready_o | cfg_index_i cfg_data_i
//
// One request at a time: capture, lookup, decide, then for an add the oldest
// entries are evicted one at a time, up to ENTRIES of them, until the new entry
// fits and a slot is free, then it is inserted; then the result is held.
// Reset empties the table at once; no clearing pass. Results hold while
// out_ready_i is low; no new request is taken until the result is taken.
module byte_capacity_lru_cache_unit #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [63:0] key_i,
  input  logic [31:0] data_handle_i,
  input  logic [31:0] element_size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] hit_handle_o,
  output logic [4:0]  evicted_count_o,
  output logic [4:0]  entry_count_o,
  output logic [39:0] used_bytes_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  logic [31:0] cap_q, max_el_q;
  blc_pkg::cmd_t cmd;
  blc_pkg::sts_t sts;
  logic show_hit;
  logic [31:0] slot_handle;

  assign cfg_ready_o = 1'b1;

  // hold config registers; writes must come only while idle, which the block does not enforce
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= blc_pkg::CapReset;
      max_el_q <= blc_pkg::MaxElReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == blc_pkg::CfgCapacity) cap_q <= cfg_data_i;
      else max_el_q <= cfg_data_i;
    end
  end

  blc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd), .status_o, .show_hit_o(show_hit)
  );

  blc_datapath #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .op_i, .key_i, .data_handle_i,
    .element_size_i, .cap_i(cap_q), .max_el_i(max_el_q), .hit_handle_o(slot_handle),
    .evicted_count_o, .entry_count_o, .used_bytes_o
  );

  // report the handle only for a get hit
  assign hit_handle_o = show_hit ? slot_handle : 32'd0;

  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.evict && cmd.insert)) else $error("evict and insert together");
  a_hit_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && show_hit |-> status_o == blc_pkg::StGetHit)
    else $error("handle shown without hit");
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("request taken while result waits");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(entry_count_o) <= ENTRIES) else $error("count overflow");
endmodule

>>> bench/testbench.sv
// Self-checking bench for byte_capacity_lru_cache_unit: predicts each result of
// the size-aware LRU cache and compares it with the block's output.
// Depends on blc_pkg and the RTL of the cache unit.
`timescale 1ns / 1ps

module testbench;

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic        op;
    logic [63:0] key;
    logic [31:0] handle;
    logic [31:0] size;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] hit_handle;
    logic [4:0]  evicted;
    logic [4:0]  entries;
    logic [39:0] used;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic op_i = 1'b0;
  logic [63:0] key_i = '0;
  logic [31:0] data_handle_i = '0;
  logic [31:0] element_size_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] status_o;
  logic [31:0] hit_handle_o;
  logic [4:0] evicted_count_o;
  logic [4:0] entry_count_o;
  logic [39:0] used_bytes_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [0:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  byte_capacity_lru_cache_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: mirror of the slot table and the two registers.
  logic [63:0] mk_key [NSLOT];
  logic [31:0] mk_handle [NSLOT];
  logic [31:0] mk_size [NSLOT];
  logic        mk_valid [NSLOT];
  int unsigned mk_rank [NSLOT];
  int unsigned mk_count;
  logic [63:0] mk_bytes;
  logic [31:0] mk_capacity;
  logic [31:0] mk_max_elem;

  request_t pending_requests[$];
  outcome_t expected_outcomes[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;
  logic in_taken = 1'b0;
  logic [63:0] key_pool [8];

  // Age every valid entry younger than slot s, then make s most recent.
  function automatic void make_recent(int s);
    for (int i = 0; i < NSLOT; i++)
      if (mk_valid[i] && i != s && mk_rank[i] < mk_rank[s]) mk_rank[i]++;
    mk_rank[s] = 0;
  endfunction

  function automatic outcome_t predict_access(request_t rq);
    outcome_t res;
    int s;
    int best;
    int freeslot;
    s = -1;
    res = '0;
    for (int i = 0; i < NSLOT; i++)
      if (s < 0 && mk_valid[i] && mk_key[i] == rq.key) s = i;
    if (!rq.op) begin
      if (s >= 0) begin
        make_recent(s);
        res.hit_handle = mk_handle[s];
        res.status = blc_pkg::StGetHit;
      end else begin
        res.status = blc_pkg::StGetMiss;
      end
    end else if (rq.size > mk_max_elem) begin
      res.status = blc_pkg::StRejected;
    end else if (s >= 0) begin
      mk_bytes = mk_bytes - mk_size[s] + rq.size;
      mk_size[s] = rq.size;
      mk_handle[s] = rq.handle;
      make_recent(s);
      res.status = blc_pkg::StUpdated;
    end else begin
      // Drop least recent entries until the new size fits and a slot is free.
      while (mk_count > 0 &&
             (mk_bytes + rq.size > {32'd0, mk_capacity} || mk_count >= NSLOT)) begin
        best = -1;
        for (int i = 0; i < NSLOT; i++)
          if (mk_valid[i] && (best < 0 || mk_rank[i] > mk_rank[best])) best = i;
        mk_valid[best] = 1'b0;
        mk_bytes -= mk_size[best];
        mk_count--;
        res.evicted++;
      end
      freeslot = -1;
      for (int i = 0; i < NSLOT; i++)
        if (freeslot < 0 && !mk_valid[i]) freeslot = i;
      for (int j = 0; j < NSLOT; j++)
        if (mk_valid[j]) mk_rank[j]++;
      mk_valid[freeslot] = 1'b1;
      mk_key[freeslot] = rq.key;
      mk_handle[freeslot] = rq.handle;
      mk_size[freeslot] = rq.size;
      mk_rank[freeslot] = 0;
      mk_count++;
      mk_bytes += rq.size;
      res.status = blc_pkg::StAdded;
    end
    res.entries = mk_count[4:0];
    res.used = mk_bytes[39:0];
    return res;
  endfunction

  // Driver: present the head of the queue, hold it until accepted.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // hold the request
      end else if (pending_requests.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        op_i <= pending_requests[0].op;
        key_i <= pending_requests[0].key;
        data_handle_i <= pending_requests[0].handle;
        element_size_i <= pending_requests[0].size;
      end else begin
        in_valid_i <= 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on accepted requests, check accepted results.
  always @(posedge clk_i) begin
    outcome_t want;
    cycle_count <= cycle_count + 1;
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_outcomes.push_back(predict_access(pending_requests[0]));
      void'(pending_requests.pop_front());
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_outcomes.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o); error_count++;
        end
        if (hit_handle_o !== want.hit_handle) begin
          $error("hit_handle: expected %h, got %h", want.hit_handle, hit_handle_o);
          error_count++;
        end
        if (evicted_count_o !== want.evicted) begin
          $error("evicted_count: expected %0d, got %0d", want.evicted, evicted_count_o);
          error_count++;
        end
        if (entry_count_o !== want.entries) begin
          $error("entry_count: expected %0d, got %0d", want.entries, entry_count_o);
          error_count++;
        end
        if (used_bytes_o !== want.used) begin
          $error("used_bytes: expected %h, got %h", want.used, used_bytes_o);
          error_count++;
        end
      end
    end
  end

  // Abort on a hung run.
  always @(posedge clk_i) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic queue_request(logic op, logic [63:0] key, logic [31:0] handle,
                               logic [31:0] size);
    request_t rq;
    rq.op = op; rq.key = key; rq.handle = handle; rq.size = size;
    pending_requests.push_back(rq);
  endtask

  task automatic drain_all();
    while (pending_requests.size() > 0 || expected_outcomes.size() > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Write one register while the cache is idle.
  task automatic write_register(logic [0:0] idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == blc_pkg::CfgCapacity) mk_capacity = value;
    else mk_max_elem = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand_key64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly small sizes so capacity evictions happen with a modest budget.
  function automatic logic [31:0] pick_size(logic [31:0] cap);
    int r;
    r = $urandom_range(99);
    if (r < 5) return 32'd0;
    if (r < 10) return $urandom();
    if (cap == 0) return $urandom_range(100);
    return $urandom_range(cap / 3 + 1);
  endfunction

  task automatic run_random(int count, logic [31:0] cap);
    logic [63:0] k;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 75) k = key_pool[$urandom_range(7)];
      else k = rand_key64();
      queue_request(1'($urandom_range(1)), k, $urandom(), pick_size(cap));
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      mk_valid[i] = 1'b0; mk_rank[i] = 0;
      mk_key[i] = '0; mk_handle[i] = '0; mk_size[i] = '0;
    end
    mk_count = 0;
    mk_bytes = '0;
    mk_capacity = blc_pkg::CapReset;
    mk_max_elem = blc_pkg::MaxElReset;
    for (int i = 0; i < 8; i++) key_pool[i] = rand_key64();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: defaults, miss, add, hit, update, reject, zero size, extremes.
    queue_request(1'b0, 64'h0, 32'h0, 32'h0);
    queue_request(1'b1, 64'h0, 32'hFFFF_FFFF, 32'h0);
    queue_request(1'b0, 64'h0, 32'h0, 32'h0);
    queue_request(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678, blc_pkg::MaxElReset);
    queue_request(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'hA5A5_A5A5, 32'd7);
    queue_request(1'b1, 64'h55, 32'h1, blc_pkg::MaxElReset + 32'd1);
    queue_request(1'b1, 64'h55, 32'h1, 32'hFFFF_FFFF);
    queue_request(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    // Fill the slot table past full: the fifteenth add must evict.
    for (int i = 1; i <= 18; i++) queue_request(1'b1, 64'h100 + i, i, 32'd1);
    drain_all();

    // Tight budget with the largest element limit: oversize put clears all,
    // then an update runs over capacity.
    write_register(blc_pkg::CfgCapacity, 32'd100);
    write_register(blc_pkg::CfgMaxElem, 32'hFFFF_FFFF);
    queue_request(1'b1, 64'h200, 32'h2, 32'd1000);
    queue_request(1'b1, 64'h200, 32'h3, 32'hFFFF_FFFF);
    queue_request(1'b1, 64'h201, 32'h4, 32'd5);
    drain_all();

    // Random phases over several register settings and idle profiles.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      case (ph)
        0: begin write_register(blc_pkg::CfgCapacity, 32'd0);
                 write_register(blc_pkg::CfgMaxElem, 32'd0); end
        1: begin write_register(blc_pkg::CfgCapacity, 32'hFFFF_FFFF);
                 write_register(blc_pkg::CfgMaxElem, 32'hFFFF_FFFF); end
        2: begin write_register(blc_pkg::CfgCapacity, blc_pkg::CapReset);
                 write_register(blc_pkg::CfgMaxElem, blc_pkg::MaxElReset); end
        default: begin
          write_register(blc_pkg::CfgCapacity, $urandom_range(5000));
          write_register(blc_pkg::CfgMaxElem, $urandom_range(2000));
        end
      endcase
      run_random(66, mk_capacity);
      drain_all();
    end

    if (error_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
